// ----- hw/rtl/cufs_pkg.sv -----
// ----------------------------------------------------------------------------
// cufs_pkg: shared constants and types for the cyclic UTF-8 frame store
// Widths, action codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package cufs_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int CP_W        = 21;

    localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_GET     = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;     // feed input byte to the decoder
        logic restart;  // empty store, rewind index, clear decoder
        logic fetch;    // read code point at current index
        logic advance;  // step index cyclically
        logic first;    // rewind byte counter
        logic emit;     // load next encoded byte into output register
    } cufs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic count_zero;
        logic len_zero;
        logic byte_last;
        logic out_free;
    } cufs_status_t;

endpackage

// ----- hw/rtl/cufs_ctrl.sv -----
// ----------------------------------------------------------------------------
// cufs_ctrl: controller for the cyclic UTF-8 frame store
// Takes input transactions and sequences the read and byte-emit steps.
// ----------------------------------------------------------------------------
module cufs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_action,
    input  cufs_pkg::cufs_status_t status,
    output cufs_pkg::cufs_cmd_t    cmd
);
    import cufs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       s_fire;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_action == ACT_LOAD) begin
                        cmd.load = 1'b1;
                    end else if (s_action == ACT_RESTART) begin
                        cmd.restart = 1'b1;
                    end else if (s_action == ACT_GET && !status.count_zero) begin
                        cmd.fetch  = 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                // code point above the Unicode range: skip it, no bytes
                if (status.len_zero) begin
                    cmd.advance = 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    cmd.first  = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.byte_last) begin
                        cmd.advance = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/cufs_datapath.sv -----
// ----------------------------------------------------------------------------
// cufs_datapath: decoder, code point store, index and encoder
// Streaming UTF-8 decode into the store, cyclic readback and re-encode.
// ----------------------------------------------------------------------------
module cufs_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0]            s_data_byte,
    input  cufs_pkg::cufs_cmd_t    cmd,
    output cufs_pkg::cufs_status_t status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_last
);
    import cufs_pkg::*;

    logic [CP_W-1:0]  mem [STORE_DEPTH];
    logic [CP_W-1:0]  rd_data_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] index_reg, index_next;
    logic [CP_W-1:0]  partial_reg, partial_next;
    logic [1:0]       pend_reg, pend_next;
    logic [1:0]       k_reg, k_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       out_byte_reg;
    logic             last_reg;

    logic             store_we;
    logic [CP_W-1:0]  store_cp;
    logic [CP_W-1:0]  cont_cp;
    logic [CNT_W-1:0] index_inc;
    logic [IDX_W-1:0] rd_addr;
    logic [2:0]       enc_len;
    logic [1:0]       rem;
    logic [5:0]       sextet;
    logic [7:0]       enc_byte;
    logic             is_last;

    // ---------------- decoder ----------------
    assign cont_cp = {partial_reg[CP_W-7:0], s_data_byte[5:0]};

    always_comb begin
        partial_next = partial_reg;
        pend_next    = pend_reg;
        store_we     = 1'b0;
        store_cp     = cont_cp;
        if (cmd.restart) begin
            partial_next = '0;
            pend_next    = '0;
        end else if (cmd.load) begin
            if (pend_reg != 2'd0 && s_data_byte[7:6] == 2'b10) begin
                pend_next = pend_reg - 2'd1;
                if (pend_reg == 2'd1) begin
                    store_we     = 1'b1;
                    partial_next = '0;
                end else begin
                    partial_next = cont_cp;
                end
            end else begin
                // fresh lead byte; any pending sequence is abandoned
                partial_next = '0;
                pend_next    = '0;
                if (s_data_byte[7] == 1'b0) begin
                    store_we = 1'b1;
                    store_cp = {{(CP_W-8){1'b0}}, s_data_byte};
                end else if (s_data_byte[7:5] == 3'b110) begin
                    partial_next = {{(CP_W-5){1'b0}}, s_data_byte[4:0]};
                    pend_next    = 2'd1;
                end else if (s_data_byte[7:4] == 4'b1110) begin
                    partial_next = {{(CP_W-4){1'b0}}, s_data_byte[3:0]};
                    pend_next    = 2'd2;
                end else if (s_data_byte[7:3] == 5'b11110) begin
                    partial_next = {{(CP_W-3){1'b0}}, s_data_byte[2:0]};
                    pend_next    = 2'd3;
                end
            end
        end
    end

    // ---------------- store count and read index ----------------
    assign index_inc = {1'b0, index_reg} + CNT_W'(1);
    assign rd_addr   = ({1'b0, index_reg} >= count_reg) ? '0 : index_reg;

    always_comb begin
        count_next = count_reg;
        index_next = index_reg;
        if (cmd.restart) begin
            count_next = '0;
            index_next = '0;
        end else begin
            if (store_we && count_reg < CNT_W'(STORE_DEPTH)) begin
                count_next = count_reg + CNT_W'(1);
            end
            if (cmd.advance) begin
                index_next = (index_inc >= count_reg) ? '0 : index_inc[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we && !cmd.restart && count_reg < CNT_W'(STORE_DEPTH)) begin
            mem[count_reg[IDX_W-1:0]] <= store_cp;
        end
        if (cmd.fetch) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // ---------------- encoder ----------------
    always_comb begin
        if (rd_data_reg <= CP_W'(21'h7F)) begin
            enc_len = 3'd1;
        end else if (rd_data_reg <= CP_W'(21'h7FF)) begin
            enc_len = 3'd2;
        end else if (rd_data_reg <= CP_W'(21'hFFFF)) begin
            enc_len = 3'd3;
        end else if (rd_data_reg <= CP_MAX) begin
            enc_len = 3'd4;
        end else begin
            enc_len = 3'd0;
        end
    end

    // sextets still to follow after the current byte
    assign rem     = enc_len[1:0] - 2'd1 - k_reg;
    assign is_last = (k_reg == 2'(enc_len - 3'd1));

    always_comb begin
        case (rem)
            2'd0:    sextet = rd_data_reg[5:0];
            2'd1:    sextet = rd_data_reg[11:6];
            2'd2:    sextet = rd_data_reg[17:12];
            default: sextet = {3'b000, rd_data_reg[20:18]};
        endcase
        if (k_reg == 2'd0) begin
            case (enc_len)
                3'd2:    enc_byte = {3'b110, rd_data_reg[10:6]};
                3'd3:    enc_byte = {4'b1110, rd_data_reg[15:12]};
                3'd4:    enc_byte = {5'b11110, rd_data_reg[20:18]};
                default: enc_byte = {1'b0, rd_data_reg[6:0]};
            endcase
        end else begin
            enc_byte = {2'b10, sextet};
        end
    end

    always_comb begin
        k_next = k_reg;
        if (cmd.first) begin
            k_next = '0;
        end else if (cmd.emit) begin
            k_next = k_reg + 2'd1;
        end
    end

    // ---------------- output register ----------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_byte_reg <= enc_byte;
            last_reg     <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            index_reg   <= '0;
            partial_reg <= '0;
            pend_reg    <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            index_reg   <= index_next;
            partial_reg <= partial_next;
            pend_reg    <= pend_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign status.count_zero = (count_reg == '0);
    assign status.len_zero   = (enc_len == 3'd0);
    assign status.byte_last  = is_last;
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid    = m_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_last     = last_reg;

endmodule

// ----- hw/rtl/cyclic_utf8_frame_store_unit.sv -----
// Loads and restarts are taken one item per cycle while no get is in progress;
// a get reads the store into a register, then the FETCH and EMIT states send its
// bytes through the output register, one byte per cycle while the receiver takes
// them. The input is held off until the last byte of a get has been emitted (no
// bytes for a point above U+10FFFF). Reset (aresetn, synchronous, active
// low) empties the store and the decoder; contents stay, reads stay below count.
// ----------------------------------------------------------------------------
// cyclic_utf8_frame_store_unit: UTF-8 frame store, top level
// Streaming UTF-8 decoder into a code point store with cyclic re-encoding.
// ----------------------------------------------------------------------------
module cyclic_utf8_frame_store_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last
);
    import cufs_pkg::*;

    cufs_cmd_t    cmd;
    cufs_status_t status;

    cufs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .status   (status),
        .cmd      (cmd)
    );

    cufs_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data_byte (s_data_byte),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last      (m_last)
    );

endmodule

// ----- hw/rtl/cufs_checker.sv -----
// ----------------------------------------------------------------------------
// cufs_checker: port-level assertions for the UTF-8 frame store
// Checks output ordering against input transactions; bound to the top level.
// ----------------------------------------------------------------------------
module cufs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_last
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last))
        else $error("result changed while stalled");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an input transaction never produces a byte in the very next cycle
    a_no_early_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("byte appeared right after input transaction");

    // input is held off while a multi-byte encoding is in flight
    a_busy_mid_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input taken in the middle of a character");

endmodule

bind cyclic_utf8_frame_store_unit cufs_checker u_cufs_checker (.*);

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the cyclic UTF-8 frame store unit
// Streams load/get/restart transactions into the unit and checks every output
// byte against an in-bench decoder/encoder model of the code point store.
// ----------------------------------------------------------------------------
module tb_top;

    import cufs_pkg::*;

    localparam logic [1:0] ACT_IGNORED  = 2'd3;
    localparam int         RAND_ITEMS   = 420;
    localparam int         FILL_POINTS  = STORE_DEPTH + 6;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [1:0] act;
        logic [7:0] data;
    } frame_action_t;

    typedef struct packed {
        logic [7:0] octet;
        logic       last;
    } utf8_octet_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [1:0] s_action    = ACT_LOAD;
    logic [7:0] s_data_byte = 8'h00;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last;

    frame_action_t frame_actions[$];
    utf8_octet_t   encoded_octets[$];
    utf8_octet_t   got_octet;

    int  total_actions = 0;
    int  counted_items = 0;
    int  items_sent    = 0;
    bit  mismatch_seen = 1'b0;
    bit  hold_on       = 1'b0;
    bit  hold_done     = 1'b0;
    int  hold_cnt      = 0;

    // model state
    logic [CP_W-1:0]  mdl_points [STORE_DEPTH];
    logic [CNT_W-1:0] mdl_count   = '0;
    logic [IDX_W-1:0] mdl_idx     = '0;
    logic [CP_W-1:0]  mdl_partial = '0;
    logic [1:0]       mdl_pending = '0;

    cyclic_utf8_frame_store_unit DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_data_byte(s_data_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // model of the unit
    // ------------------------------------------------------------------------
    task automatic append_point(input logic [CP_W-1:0] cp);
        if (mdl_count < CNT_W'(STORE_DEPTH)) begin
            mdl_points[mdl_count[IDX_W-1:0]] = cp;
            mdl_count = mdl_count + 1'b1;
        end
    endtask

    task automatic push_octet(input logic [7:0] octet, input logic last);
        encoded_octets.push_back('{octet: octet, last: last});
    endtask

    task automatic predict_frame_bytes(input logic [1:0] act, input logic [7:0] db);
        logic [CP_W-1:0] cp;
        int              nxt;
        case (act)
            ACT_LOAD: begin
                if (mdl_pending != 0 && db[7:6] == 2'b10) begin
                    mdl_partial = {mdl_partial[CP_W-7:0], db[5:0]};
                    mdl_pending = mdl_pending - 1'b1;
                    if (mdl_pending == 0) begin
                        append_point(mdl_partial);
                        mdl_partial = '0;
                    end
                end else begin
                    // truncated sequence: drop partial, re-decode as lead
                    mdl_partial = '0;
                    mdl_pending = '0;
                    if (db[7] == 1'b0) begin
                        append_point(CP_W'(db));
                    end else if (db[7:5] == 3'b110) begin
                        mdl_partial = CP_W'(db[4:0]);
                        mdl_pending = 2'd1;
                    end else if (db[7:4] == 4'b1110) begin
                        mdl_partial = CP_W'(db[3:0]);
                        mdl_pending = 2'd2;
                    end else if (db[7:3] == 5'b11110) begin
                        mdl_partial = CP_W'(db[2:0]);
                        mdl_pending = 2'd3;
                    end
                end
            end
            ACT_GET: begin
                if (mdl_count != 0) begin
                    if (CNT_W'(mdl_idx) >= mdl_count) mdl_idx = '0;
                    cp = mdl_points[mdl_idx];
                    if (cp <= 21'h7F) begin
                        push_octet(cp[7:0], 1'b1);
                    end else if (cp <= 21'h7FF) begin
                        push_octet({3'b110, cp[10:6]}, 1'b0);
                        push_octet({2'b10, cp[5:0]}, 1'b1);
                    end else if (cp <= 21'hFFFF) begin
                        push_octet({4'b1110, cp[15:12]}, 1'b0);
                        push_octet({2'b10, cp[11:6]}, 1'b0);
                        push_octet({2'b10, cp[5:0]}, 1'b1);
                    end else if (cp <= CP_MAX) begin
                        push_octet({5'b11110, cp[20:18]}, 1'b0);
                        push_octet({2'b10, cp[17:12]}, 1'b0);
                        push_octet({2'b10, cp[11:6]}, 1'b0);
                        push_octet({2'b10, cp[5:0]}, 1'b1);
                    end
                    nxt = (int'(mdl_idx) + 1) % int'(mdl_count);
                    mdl_idx = IDX_W'(nxt);
                end
            end
            ACT_RESTART: begin
                mdl_count   = '0;
                mdl_idx     = '0;
                mdl_partial = '0;
                mdl_pending = '0;
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_item(input logic [1:0] act, input logic [7:0] data);
        frame_actions.push_back('{act: act, data: data});
        counted_items++;
    endtask

    // encode cp with n bytes; short values in long forms give overlong input
    task automatic push_point(input logic [CP_W-1:0] cp, input int n);
        case (n)
            1: push_item(ACT_LOAD, {1'b0, cp[6:0]});
            2: begin
                push_item(ACT_LOAD, {3'b110, cp[10:6]});
                push_item(ACT_LOAD, {2'b10, cp[5:0]});
            end
            3: begin
                push_item(ACT_LOAD, {4'b1110, cp[15:12]});
                push_item(ACT_LOAD, {2'b10, cp[11:6]});
                push_item(ACT_LOAD, {2'b10, cp[5:0]});
            end
            default: begin
                push_item(ACT_LOAD, {5'b11110, cp[20:18]});
                push_item(ACT_LOAD, {2'b10, cp[17:12]});
                push_item(ACT_LOAD, {2'b10, cp[11:6]});
                push_item(ACT_LOAD, {2'b10, cp[5:0]});
            end
        endcase
    endtask

    function automatic int idle_pct(input bit rx_side);
        int third;
        third = total_actions / 3;
        if (items_sent < third)       return rx_side ? 81 : 36;
        else if (items_sent < 2*third) return rx_side ? 36 : 81;
        else                           return 0;
    endfunction

    // ------------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_frame_bytes(s_action, s_data_byte);
            if (!s_valid || s_ready) begin
                if (frame_actions.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
                    s_valid     <= 1'b1;
                    s_action    <= frame_actions[0].act;
                    s_data_byte <= frame_actions[0].data;
                    void'(frame_actions.pop_front());
                    items_sent++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off once the no-idle phase starts
    always @(posedge aclk) begin
        if (aresetn && !hold_done && !hold_on && idle_pct(1'b1) == 0) begin
            hold_on  <= 1'b1;
            hold_cnt <= 0;
        end else if (hold_on) begin
            if (hold_cnt == HOLD_CYCLES) begin
                hold_on   <= 1'b0;
                hold_done <= 1'b1;
            end else begin
                hold_cnt <= hold_cnt + 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else          m_ready <= !hold_on && ($urandom_range(0, 99) >= idle_pct(1'b1));
    end

    // ------------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (encoded_octets.size() == 0) begin
                $error("unexpected transaction: out_byte %h last %b", m_out_byte, m_last);
                mismatch_seen = 1'b1;
            end else begin
                got_octet = encoded_octets.pop_front();
                if (got_octet.octet !== m_out_byte) begin
                    $error("out_byte mismatch: expected %h, actual %h",
                           got_octet.octet, m_out_byte);
                    mismatch_seen = 1'b1;
                end
                if (got_octet.last !== m_last) begin
                    $error("last mismatch: expected %b, actual %b", got_octet.last, m_last);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence and end of test
    // ------------------------------------------------------------------------
    initial begin
        int              rand_base;
        int              kind;
        int              n;
        int              k;
        bit              filled;
        logic [CP_W-1:0] cp;
        logic [7:0]      b;

        filled = 1'b0;

        // directed: get on empty, extremes of the 1-, 2- and 4-byte lengths, overlong,
        // truncated sequence into a surrogate, above-range point, bad leads
        push_item(ACT_GET, 8'hFF);
        push_item(ACT_LOAD, 8'h7F);
        push_item(ACT_LOAD, 8'hC0);
        push_item(ACT_LOAD, 8'h80);
        push_item(ACT_LOAD, 8'hDF);
        push_item(ACT_LOAD, 8'hBF);
        push_item(ACT_LOAD, 8'hF0);
        push_item(ACT_LOAD, 8'h90);
        push_item(ACT_LOAD, 8'hED);
        push_item(ACT_LOAD, 8'hA0);
        push_item(ACT_LOAD, 8'h80);
        push_point(CP_MAX, 4);
        push_point(21'h1FFFFF, 4);
        push_item(ACT_LOAD, 8'h80);
        push_item(ACT_LOAD, 8'hF8);
        push_item(ACT_IGNORED, 8'hAA);
        repeat (6) push_item(ACT_GET, 8'h00);
        push_item(ACT_RESTART, 8'h55);

        rand_base = counted_items;
        while (counted_items - rand_base < RAND_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (!filled && counted_items - rand_base > 100) begin
                // overflow the store, then read a few back
                filled = 1'b1;
                push_item(ACT_RESTART, 8'($urandom));
                repeat (FILL_POINTS) push_point(CP_W'($urandom_range(0, 127)), 1);
                push_point(21'h20AC, 3);
                repeat (4) push_item(ACT_GET, 8'($urandom));
            end else if (kind < 55) begin
                repeat ($urandom_range(1, 6)) begin
                    n  = $urandom_range(1, 4);
                    cp = CP_W'($urandom);
                    case (n)
                        1: cp = cp & 21'h7F;
                        2: cp = cp & 21'h7FF;
                        3: cp = cp & 21'hFFFF;
                        default: if ($urandom_range(0, 1)) cp = CP_W'($urandom_range(0, CP_MAX));
                    endcase
                    push_point(cp, n);
                end
                repeat ($urandom_range(0, 6)) push_item(ACT_GET, 8'($urandom));
            end else if (kind < 65) begin
                repeat ($urandom_range(1, 4)) push_item(ACT_GET, 8'($urandom));
            end else if (kind < 73) begin
                repeat ($urandom_range(1, 4)) push_item(ACT_LOAD, 8'($urandom));
            end else if (kind < 81) begin
                // lead byte followed by too few continuations
                n  = $urandom_range(2, 4);
                cp = CP_W'($urandom);
                b  = 8'($urandom);
                case (n)
                    2:       push_item(ACT_LOAD, {3'b110, b[4:0]});
                    3:       push_item(ACT_LOAD, {4'b1110, b[3:0]});
                    default: push_item(ACT_LOAD, {5'b11110, b[2:0]});
                endcase
                k = $urandom_range(0, n - 2);
                repeat (k) push_item(ACT_LOAD, {2'b10, 6'($urandom)});
                case ($urandom_range(0, 3))
                    0: push_item(ACT_GET, 8'($urandom));
                    1: push_item(ACT_RESTART, 8'($urandom));
                    default: begin
                        b = 8'($urandom);
                        if (b[7:6] == 2'b10) b[6] = 1'b1;
                        push_item(ACT_LOAD, b);
                    end
                endcase
            end else if (kind < 87) begin
                push_item(ACT_RESTART, 8'($urandom));
            end else if (kind < 91) begin
                push_item(ACT_IGNORED, 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 3)) push_item(ACT_GET, 8'($urandom));
            end
        end
        total_actions = frame_actions.size();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (frame_actions.size() != 0 || s_valid) @(posedge aclk);
        while (encoded_octets.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (encoded_octets.size() != 0) begin
            $error("%0d expected transactions never arrived", encoded_octets.size());
            mismatch_seen = 1'b1;
        end

        if (!mismatch_seen) begin
            $display("[cyclic_utf8_frame_store_unit] OK");
        end else begin
            $display("[cyclic_utf8_frame_store_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout waiting for transactions");
        $display("[cyclic_utf8_frame_store_unit] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/cufs_pkg.sv
hw/rtl/cufs_ctrl.sv
hw/rtl/cufs_datapath.sv
hw/rtl/cyclic_utf8_frame_store_unit.sv
hw/rtl/cufs_checker.sv
dv/tb_top.sv
